// ===== sv/ues_pkg.sv =====
package ues_pkg;

   // Control that travels with an edge key along the cell chain.
   typedef struct packed {
      logic valid;   // a key is present in this slot of the chain
      logic full;    // the store was full when the key entered
      logic done;    // the key has been stored or dropped
      logic dup;     // the key matched a stored edge
   } tok_ctrl_type;

endpackage

// ===== sv/ues_cell.sv =====
module ues_cell #(
   parameter int KEY_BITS = 40
) (
   input  logic                     clock,
   input  logic                     reset,
   input  ues_pkg::tok_ctrl_type    up_ctrl,
   input  logic [KEY_BITS-1:0]      up_key,
   output ues_pkg::tok_ctrl_type    dn_ctrl,
   output logic [KEY_BITS-1:0]      dn_key,
   input  logic                     shift,
   input  logic                     nxt_valid,
   input  logic [KEY_BITS-1:0]      nxt_key,
   output logic                     cur_valid,
   output logic [KEY_BITS-1:0]      cur_key
);

   logic                  store_valid_ff, store_valid_in;
   logic [KEY_BITS-1:0]   store_key_ff, store_key_in;
   ues_pkg::tok_ctrl_type tok_ctrl_ff, tok_ctrl_in;
   logic [KEY_BITS-1:0]   tok_key_ff, tok_key_in;

   // A passing key either settles here, is found to be a copy, pushes the
   // stored key one place down, is dropped if the store is full, or simply moves on.
   always_comb begin
      store_valid_in = store_valid_ff;
      store_key_in   = store_key_ff;
      tok_ctrl_in    = up_ctrl;
      tok_key_in     = up_key;
      if (shift) begin
         store_valid_in = nxt_valid;
         store_key_in   = nxt_key;
      end else if (up_ctrl.valid && !up_ctrl.done) begin
         priority if (!store_valid_ff) begin
            store_valid_in   = 1'b1;
            store_key_in     = up_key;
            tok_ctrl_in.done = 1'b1;
         end else if (store_key_ff == up_key) begin
            tok_ctrl_in.done = 1'b1;
            tok_ctrl_in.dup  = 1'b1;
         end else if (store_key_ff > up_key) begin
            if (up_ctrl.full) begin
               tok_ctrl_in.done = 1'b1;
            end else begin
               store_key_in = up_key;
               tok_key_in   = store_key_ff;
            end
         end else begin
            tok_key_in = up_key;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         store_valid_ff <= 1'b0;
         tok_ctrl_ff    <= '0;
      end else begin
         store_valid_ff <= store_valid_in;
         tok_ctrl_ff    <= tok_ctrl_in;
      end
      store_key_ff <= store_key_in;
      tok_key_ff   <= tok_key_in;
   end

   assign dn_ctrl   = tok_ctrl_ff;
   assign dn_key    = tok_key_ff;
   assign cur_valid = store_valid_ff;
   assign cur_key   = store_key_ff;

endmodule

// ===== sv/unique_edge_sorter.sv =====
// Each edge's key walks the whole cell chain, one cell per cycle, from the injection register.
// One edge is accepted at a time: the next waits until the previous key has left the chain.
// After the final edge, unique edges leave at one per cycle while the output is not stalled.
// Synchronous active-high reset empties the store and clears the count and overflow flag.
// The stored keys themselves are not cleared; only their valid bits are.
module unique_edge_sorter #(
   parameter int MAX_EDGES   = 64,
   parameter int VERTEX_BITS = 20
) (
   input  logic                                        clock,
   input  logic                                        reset,
   // req_tdata fields, lowest bit first: vertex_a, vertex_b, zero padding.
   input  logic [((2*VERTEX_BITS+7)/8)*8-1:0]          req_tdata,
   input  logic                                        req_tvalid,
   output logic                                        req_tready,
   input  logic                                        req_tlast,
   // rsp_tdata fields, lowest bit first: low_vertex, high_vertex, zero padding.
   output logic [((2*VERTEX_BITS+7)/8)*8-1:0]          rsp_tdata,
   output logic                                        rsp_tvalid,
   input  logic                                        rsp_tready,
   output logic                                        rsp_tlast,
   // rsp_tuser fields, lowest bit first: overflow.
   output logic                                        rsp_tuser
);

   localparam int KEY_BITS   = 2 * VERTEX_BITS;
   localparam int TDATA_BITS = ((KEY_BITS + 7) / 8) * 8;
   localparam int CNT_BITS   = $clog2(MAX_EDGES + 1);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_INSERT = 2'd1;
   localparam logic [1:0] ST_EMIT   = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic                  ovf_ff, ovf_in;
   logic                  final_ff, final_in;
   ues_pkg::tok_ctrl_type inj_ctrl_ff, inj_ctrl_in;
   logic [KEY_BITS-1:0]   inj_key_ff, inj_key_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [KEY_BITS-1:0]   rsp_key_ff, rsp_key_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  rsp_ovf_ff, rsp_ovf_in;

   logic [VERTEX_BITS-1:0] vert_a, vert_b;
   logic                   accept;
   logic                   shift;

   ues_pkg::tok_ctrl_type  chain_ctrl [0:MAX_EDGES];
   logic [KEY_BITS-1:0]    chain_key  [0:MAX_EDGES];
   logic                   cell_valid [0:MAX_EDGES];
   logic [KEY_BITS-1:0]    cell_key   [0:MAX_EDGES];

   assign vert_a     = req_tdata[VERTEX_BITS-1:0];
   assign vert_b     = req_tdata[KEY_BITS-1:VERTEX_BITS];
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   // The key enters the chain from this injection register.
   assign chain_ctrl[0] = inj_ctrl_ff;
   assign chain_key[0]  = inj_key_ff;

   // Past the last cell nothing is stored, so a drain shift empties it.
   assign cell_valid[MAX_EDGES] = 1'b0;
   assign cell_key[MAX_EDGES]   = '0;

   for (genvar i = 0; i < MAX_EDGES; i++) begin : g_cell
      ues_cell #(
         .KEY_BITS (KEY_BITS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .up_ctrl   (chain_ctrl[i]),
         .up_key    (chain_key[i]),
         .dn_ctrl   (chain_ctrl[i+1]),
         .dn_key    (chain_key[i+1]),
         .shift     (shift),
         .nxt_valid (cell_valid[i+1]),
         .nxt_key   (cell_key[i+1]),
         .cur_valid (cell_valid[i]),
         .cur_key   (cell_key[i])
      );
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      final_in     = final_ff;
      inj_ctrl_in  = '0;
      inj_key_in   = inj_key_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_key_in   = rsp_key_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      shift        = 1'b0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               // Canonical order: the smaller vertex forms the upper half of the key.
               inj_ctrl_in.valid = 1'b1;
               inj_ctrl_in.full  = (count_ff == CNT_BITS'(MAX_EDGES));
               inj_key_in = (vert_a < vert_b) ? {vert_a, vert_b} : {vert_b, vert_a};
               final_in   = req_tlast;
               state_in   = ST_INSERT;
            end
         end
         ST_INSERT: begin
            // The key has left the last cell; its flags tell what happened to it.
            if (chain_ctrl[MAX_EDGES].valid) begin
               if (!chain_ctrl[MAX_EDGES].dup) begin
                  if (chain_ctrl[MAX_EDGES].full) begin
                     ovf_in = 1'b1;
                  end else begin
                     count_in = count_ff + CNT_BITS'(1);
                  end
               end
               state_in = final_ff ? ST_EMIT : ST_IDLE;
            end
         end
         ST_EMIT: begin
            // Cell zero holds the smallest remaining edge; the chain moves up behind it.
            if (count_ff == '0) begin
               ovf_in   = 1'b0;
               state_in = ST_IDLE;
            end else if (!rsp_valid_ff || rsp_tready) begin
               shift        = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_key_in   = cell_key[0];
               rsp_last_in  = (count_ff == CNT_BITS'(1));
               rsp_ovf_in   = ovf_ff;
               count_in     = count_ff - CNT_BITS'(1);
               if (count_ff == CNT_BITS'(1)) begin
                  ovf_in   = 1'b0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         final_ff     <= 1'b0;
         inj_ctrl_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         final_ff     <= final_in;
         inj_ctrl_ff  <= inj_ctrl_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      inj_key_ff  <= inj_key_in;
      rsp_key_ff  <= rsp_key_in;
      rsp_last_ff <= rsp_last_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   // The key holds the smaller vertex in its upper half, so the halves swap places
   // to put low_vertex in the low tdata bits.
   assign rsp_tdata  = TDATA_BITS'({rsp_key_ff[VERTEX_BITS-1:0],
                                    rsp_key_ff[KEY_BITS-1:VERTEX_BITS]});
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_ovf_ff;

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

// The bench streams sets of undirected edges into the sorter. A set is a run of edge
// transactions whose last one carries req_tlast. A scoreboard object mirrors the store:
// it keeps the canonical keys of the current set in ascending order and drops duplicates.
// It stops taking new keys once MAX_EDGES are held, and remembers that an edge was lost.
// On the closing edge of a set it queues one expected response per stored key.
// Each response transaction is checked against the oldest queued entry.
module tb_top;

   localparam int VB   = 20;
   localparam int ME   = 64;
   localparam int DW   = ((2 * VB + 7) / 8) * 8;
   localparam int LAT  = ME + 2;
   localparam logic [VB-1:0] VMAX = '1;

   logic          clock;
   logic          reset;
   logic [DW-1:0] req_tdata;
   logic          req_tvalid;
   logic          req_tready;
   logic          req_tlast;
   logic [DW-1:0] rsp_tdata;
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic          rsp_tlast;
   logic          rsp_tuser;

   // One unique edge as the sorter should emit it.
   typedef struct {
      logic [VB-1:0] low_v;
      logic [VB-1:0] high_v;
      logic          last;
      logic          ovf;
   } sorted_edge_type;

   // Holds the sorted, deduplicated edge set of the current run and the
   // responses that are due but not yet seen on the output.
   class edge_set_scoreboard_type;
      logic [2*VB-1:0] sorted_keys[$];
      bit              dropped;
      sorted_edge_type awaited[$];
      int              errors;

      function void note_edge(logic [VB-1:0] a, logic [VB-1:0] b, logic closes_set);
         logic [VB-1:0]   lo;
         logic [VB-1:0]   hi;
         logic [2*VB-1:0] key;
         int              pos;
         bit              present;
         sorted_edge_type r;
         lo  = (a < b) ? a : b;
         hi  = (a < b) ? b : a;
         key = {lo, hi};
         pos = 0;
         while (pos < sorted_keys.size() && sorted_keys[pos] < key)
            pos++;
         present = (pos < sorted_keys.size()) && (sorted_keys[pos] == key);
         // A duplicate is ignored even when the store is full; only a new key can be lost.
         if (!present) begin
            if (sorted_keys.size() >= ME)
               dropped = 1'b1;
            else
               sorted_keys.insert(pos, key);
         end
         if (closes_set) begin
            foreach (sorted_keys[i]) begin
               r.low_v  = sorted_keys[i][2*VB-1:VB];
               r.high_v = sorted_keys[i][VB-1:0];
               r.last   = (i == sorted_keys.size() - 1);
               r.ovf    = dropped;
               awaited  = {awaited, r};
            end
            sorted_keys.delete();
            dropped = 1'b0;
         end
      endfunction

      function void compare_field(string name, logic [VB-1:0] want, logic [VB-1:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_edge(logic [VB-1:0] low_v, logic [VB-1:0] high_v,
                               logic last, logic ovf);
         sorted_edge_type r;
         if (awaited.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual %h %h last %b ovf %b",
                     $time, low_v, high_v, last, ovf);
            errors++;
            return;
         end
         r = awaited.pop_front();
         compare_field("low_vertex", r.low_v, low_v);
         compare_field("high_vertex", r.high_v, high_v);
         compare_field("end_of_list", VB'(r.last), VB'(last));
         compare_field("overflow", VB'(r.ovf), VB'(ovf));
      endfunction
   endclass

   edge_set_scoreboard_type sb;
   int                      items_sent;
   int                      results_seen;
   bit                      long_hold_done;

   unique_edge_sorter #(
      .MAX_EDGES   (ME),
      .VERTEX_BITS (VB)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tlast  (req_tlast),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Offers one edge transaction and waits for the handshake. The sender sometimes
   // idles before the offer, except in a window of items where it runs flat out.
   // The valid is left high on return so back-to-back offers never toggle it.
   task automatic send_edge(input logic [VB-1:0] a, input logic [VB-1:0] b,
                            input logic last);
      logic [DW-1:0] word;
      int            gap;
      gap = $urandom_range(1, 5);
      if (!(items_sent >= 150 && items_sent < 230) && $urandom_range(99) < 15) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      word          = '0;
      word[VB-1:0]  = a;
      word[2*VB-1:VB] = b;
      req_tdata  <= word;
      req_tlast  <= last;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_edge(a, b, last);
      items_sent++;
   endtask

   // Sends an edge in a random orientation, so canonical ordering is always exercised.
   task automatic send_either_way(input logic [VB-1:0] a, input logic [VB-1:0] b,
                                  input logic last);
      if ($urandom_range(1))
         send_edge(b, a, last);
      else
         send_edge(a, b, last);
   endtask

   // Builds a large set: 'distinct' edges that are new by construction (the low end
   // is the index, the high end is at least 128), with repeats of earlier ones mixed in.
   // The closing edge is either one more new edge or a repeat.
   task automatic fill_store(input int distinct, input bit close_with_new);
      logic [VB-1:0] partner[128];
      int            j;
      for (int k = 0; k < distinct; k++) begin
         partner[k] = VB'($urandom_range(32'(VMAX), 128));
         send_either_way(VB'(k), partner[k], 1'b0);
         if ($urandom_range(3) == 0) begin
            j = $urandom_range(k, 0);
            send_either_way(VB'(j), partner[j], 1'b0);
         end
      end
      if (close_with_new) begin
         partner[distinct] = VB'($urandom_range(32'(VMAX), 128));
         send_either_way(VB'(distinct), partner[distinct], 1'b1);
      end else begin
         j = $urandom_range(distinct - 1, 0);
         send_either_way(VB'(j), partner[j], 1'b1);
      end
   endtask

   // A short set. Narrow sets draw from a handful of vertices, so duplicates,
   // self-loops and reversed repeats are common; wide sets use the full range.
   task automatic send_small_set();
      int            n;
      bit            narrow;
      logic [VB-1:0] a;
      logic [VB-1:0] b;
      n      = $urandom_range(12, 1);
      narrow = 1'($urandom_range(1));
      for (int i = 0; i < n; i++) begin
         a = narrow ? VB'($urandom_range(7)) : VB'($urandom);
         b = narrow ? VB'($urandom_range(7)) : VB'($urandom);
         send_edge(a, b, i == n - 1);
      end
   endtask

   // Each response transaction is checked at the edge where it is taken.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_edge(rsp_tdata[VB-1:0], rsp_tdata[2*VB-1:VB], rsp_tlast, rsp_tuser);
         results_seen++;
      end
   end

   // Receiver. It stalls about 15 percent of the time, never while a window of
   // responses goes by, and once holds off for a long stretch so that the sorter
   // backs up and has to stop taking edges.
   initial begin
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!long_hold_done && results_seen >= 30) begin
            long_hold_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (600) @(posedge clock);
         end else begin
            rsp_tready <= (results_seen >= 150 && results_seen < 260) ||
                          ($urandom_range(99) >= 15);
            @(posedge clock);
         end
      end
   end

   initial begin
      int set_no;
      sb             = new();
      items_sent     = 0;
      results_seen   = 0;
      long_hold_done = 1'b0;
      reset      <= 1'b1;
      req_tdata  <= '0;
      req_tvalid <= 1'b0;
      req_tlast  <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // A set of one edge, given reversed, at the extremes of the range.
      send_edge(VMAX, VB'(0), 1'b1);
      // Self-loops, reversed repeats, the corners of the range, and a closing
      // edge that repeats one already held.
      send_edge(VB'(5), VB'(5), 1'b0);
      send_edge(VB'(7), VB'(3), 1'b0);
      send_edge(VB'(3), VB'(7), 1'b0);
      send_edge(VB'(0), VB'(0), 1'b0);
      send_edge(VMAX, VMAX, 1'b0);
      send_edge(VMAX, VB'(0), 1'b0);
      send_edge(VB'(0), VMAX, 1'b0);
      send_edge(VB'(1), VMAX - VB'(1), 1'b0);
      send_edge(VB'(7), VB'(3), 1'b1);
      // Alternating bit patterns on both vertex fields.
      send_edge(20'hAAAAA, 20'h55555, 1'b0);
      send_edge(20'h55555, 20'hAAAAA, 1'b1);
      send_edge(VB'(12), VB'(34), 1'b1);

      // The first random sets overflow the store and then fill it exactly; after
      // that, mostly short sets with an occasional large one.
      set_no = 0;
      while (items_sent < 360) begin
         if (set_no == 0)
            fill_store(ME + 6, 1'b1);
         else if (set_no == 1)
            fill_store(ME, 1'b0);
         else if ($urandom_range(99) < 4)
            fill_store($urandom_range(ME + 8, ME - 4), 1'($urandom_range(1)));
         else
            send_small_set();
         set_no++;
      end
      req_tvalid <= 1'b0;

      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (4 * LAT) @(posedge clock);
      if (sb.errors == 0)
         $display("[unique_edge_sorter] OK");
      else
         $display("[unique_edge_sorter] ERROR");
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #1000000;
      $display("[unique_edge_sorter] ERROR");
      $finish;
   end

endmodule
